[src/utf8_decode_validate_assert.svh]
// assertion macros for the checker file
`ifndef UTF8_DECODE_VALIDATE_ASSERT_SVH
`define UTF8_DECODE_VALIDATE_ASSERT_SVH

// checked on every clock edge outside reset
`define U8DV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define U8DV_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/u8dv_pkg.sv]
`timescale 1ns / 1ps
package u8dv_pkg;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_STRAY    = 2'd1;
   localparam logic [1:0] STATUS_INVALID  = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;

   typedef struct packed {
      logic [31:0] code_point;
      logic [1:0]  status;
      logic        last_result;
   } result_type;

   // trailing byte count from the lead byte class
   function automatic logic [2:0] lead_trailers(input logic [7:0] b);
      logic [2:0] t;
      if (b < 8'hC0)      t = 3'd0;
      else if (b < 8'hE0) t = 3'd1;
      else if (b < 8'hF0) t = 3'd2;
      else if (b < 8'hF8) t = 3'd3;
      else if (b < 8'hFC) t = 3'd4;
      else                t = 3'd5;
      return t;
   endfunction

   // offset removing the lead and trailer marker bits
   function automatic logic [31:0] seq_offset(input logic [2:0] t);
      logic [31:0] off;
      case (t)
         3'd0:    off = 32'h0000_0000;
         3'd1:    off = 32'h0000_3080;
         3'd2:    off = 32'h000E_2080;
         3'd3:    off = 32'h03C8_2080;
         3'd4:    off = 32'hFA08_2080;
         default: off = 32'h8208_2080;
      endcase
      return off;
   endfunction

   // shortest-form and range check
   function automatic logic [1:0] check_value(input logic [31:0] cp, input logic [2:0] t);
      logic [1:0] st;
      if (cp < 32'h80)                 st = STATUS_INVALID;
      else if (cp < 32'h800)           st = (t == 3'd1) ? STATUS_OK : STATUS_INVALID;
      else if (cp < 32'h1_0000)        st = (t == 3'd2) ? STATUS_OK : STATUS_INVALID;
      else if (cp <= MAX_CODE_POINT)   st = (t == 3'd3) ? STATUS_OK : STATUS_INVALID;
      else                             st = STATUS_INVALID;
      return st;
   endfunction

endpackage

[src/utf8_decode_validate.sv]
`timescale 1ns / 1ps
// utf8 stream decoder with validation
//
// request channel: one byte per beat on req_data_byte, req_end_of_stream set on
// the final byte of a stream. a beat is taken when req_valid is high and
// req_stall is low.
// response channel: at most one beat per request beat, carrying rsp_code_point,
// rsp_status (ok, stray continuation, overlong or out of range, truncated) and
// rsp_last_result. trailers that do not close a sequence or end the stream give
// no response. a response is registered in the output or skid register.
// throughput: one byte per cycle when not stalled; the decode is a single
// shift-add, offset subtract and range compare ahead of the output registers.
// a skid register behind the output register lets the block take one more byte
// while the receiver stalls; req_stall rises only once the skid register holds
// a beat, and the response payload holds steady while rsp_stall is high.
// reset (synchronous, active high) clears the sequence state and empties both
// output registers; the next byte starts a new stream.
module utf8_decode_validate import u8dv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_code_point,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_result
);

   // sequence state
   logic [2:0]  remaining_ff, remaining_in;
   logic [2:0]  trailers_ff, trailers_in;
   logic [31:0] acc_ff, acc_in;

   // output register and skid register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic        accept;
   logic        new_valid;
   result_type  new_res;
   logic [31:0] acc_shift;
   logic [2:0]  remaining_dec;
   logic [31:0] cp;
   logic        out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   // decode of one byte against the open sequence
   always_comb begin
      remaining_in  = remaining_ff;
      trailers_in   = trailers_ff;
      acc_in        = acc_ff;
      new_valid     = 1'b0;
      new_res       = '{code_point: 32'd0, status: STATUS_OK,
                        last_result: req_end_of_stream};
      acc_shift     = {acc_ff[25:0], 6'd0} + {24'd0, req_data_byte};
      remaining_dec = remaining_ff - 3'd1;
      cp            = acc_shift - seq_offset(trailers_ff);

      if (accept) begin
         if (remaining_ff == 3'd0) begin
            if (req_data_byte < 8'h80) begin
               // plain ascii byte
               new_valid          = 1'b1;
               new_res.code_point = {24'd0, req_data_byte};
               new_res.status     = STATUS_OK;
            end else if (req_data_byte < 8'hC0) begin
               // continuation byte with no lead in front of it
               new_valid          = 1'b1;
               new_res.code_point = {24'd0, req_data_byte};
               new_res.status     = STATUS_STRAY;
            end else if (req_end_of_stream) begin
               // lead byte at end of stream
               new_valid      = 1'b1;
               new_res.status = STATUS_TRUNCATED;
            end else begin
               // open a sequence
               acc_in       = {24'd0, req_data_byte};
               trailers_in  = lead_trailers(req_data_byte);
               remaining_in = lead_trailers(req_data_byte);
            end
         end else if (remaining_dec != 3'd0) begin
            if (req_end_of_stream) begin
               // stream ended inside the sequence
               new_valid      = 1'b1;
               new_res.status = STATUS_TRUNCATED;
               remaining_in   = 3'd0;
               trailers_in    = 3'd0;
               acc_in         = 32'd0;
            end else begin
               acc_in       = acc_shift;
               remaining_in = remaining_dec;
            end
         end else begin
            // last trailer closes the sequence
            new_valid          = 1'b1;
            new_res.code_point = cp;
            new_res.status     = check_value(cp, trailers_ff);
            remaining_in       = 3'd0;
            trailers_in        = 3'd0;
            acc_in             = 32'd0;
         end
      end
   end

   // output register and skid steering
   always_comb begin
      out_free      = !out_valid_ff || !rsp_stall;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // skid drains first, no byte is taken while it is full
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = new_valid;
            out_in       = new_res;
         end
      end else if (new_valid) begin
         // receiver stalled, park the new beat
         skid_valid_in = 1'b1;
         skid_in       = new_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff  <= 3'd0;
         trailers_ff   <= 3'd0;
         acc_ff        <= 32'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         remaining_ff  <= remaining_in;
         trailers_ff   <= trailers_in;
         acc_ff        <= acc_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_point  = out_ff.code_point;
   assign rsp_status      = out_ff.status;
   assign rsp_last_result = out_ff.last_result;

endmodule

[src/u8dv_checker.sv]
`timescale 1ns / 1ps
`include "utf8_decode_validate_assert.svh"

module u8dv_checker import u8dv_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_end_of_stream,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_code_point,
   input logic [1:0]  rsp_status,
   input logic        rsp_last_result
);

   // both channels quiet right after reset
   `U8DV_ASSERT_ALWAYS(a_reset_quiet, $fell(reset) |-> !rsp_valid && !req_stall, "busy after reset")

   // stalled response beat holds
   `U8DV_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point) && $stable(rsp_status) && $stable(rsp_last_result), "response changed under stall")

   // truncation only at end of stream, with a zero value
   `U8DV_ASSERT(a_trunc_form, rsp_valid && rsp_status == STATUS_TRUNCATED |-> rsp_code_point == 32'd0 && rsp_last_result, "bad truncation beat")

   // a stray beat carries a continuation byte
   `U8DV_ASSERT(a_stray_form, rsp_valid && rsp_status == STATUS_STRAY |-> rsp_code_point[31:8] == 24'd0 && rsp_code_point[7:6] == 2'b10, "bad stray beat")

   // an ok beat does not exceed the largest code point
   `U8DV_ASSERT(a_ok_range, rsp_valid && rsp_status == STATUS_OK |-> rsp_code_point <= MAX_CODE_POINT, "ok value out of range")

endmodule

bind utf8_decode_validate u8dv_checker u_checker (.*);
